// ----- hw/rtl/mts_pkg.sv -----
package mts_pkg;

    localparam int STACK_DEPTH_DEF = 256;
    localparam int DATA_W          = 32;
    localparam int OUT_W           = 72;

    typedef enum logic [1:0] {
        ST_OK        = 2'd0,
        ST_OVERFLOW  = 2'd1,
        ST_UNDERFLOW = 2'd2
    } status_t;

    typedef enum logic [1:0] {
        S_IDLE,
        S_LOAD,
        S_FINISH
    } state_t;

    // Commands from the controller to the datapath.
    typedef struct packed {
        logic accept;
        logic load_tops;
        logic load_out;
    } dp_cmd_t;

    // Status from the datapath to the controller.
    typedef struct packed {
        logic pop_ok;
        logic out_free;
    } dp_stat_t;

endpackage

// ----- hw/rtl/mts_ctrl.sv -----
module mts_ctrl
(
    input  logic              clk,
    input  logic              rst_n,
    input  logic              in_valid,
    input  logic              in_pop,
    output logic              in_ready,
    input  mts_pkg::dp_stat_t stat,
    output mts_pkg::dp_cmd_t  cmd
);

    mts_pkg::state_t state_reg;
    mts_pkg::state_t state_next;

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            state_reg <= mts_pkg::S_IDLE;
        end
        else
        begin
            state_reg <= state_next;
        end
    end

    always_comb
    begin
        state_next    = state_reg;
        in_ready      = 1'b0;
        cmd.accept    = 1'b0;
        cmd.load_tops = 1'b0;
        cmd.load_out  = 1'b0;
        case (state_reg)
            mts_pkg::S_IDLE:
            begin
                in_ready   = 1'b1;
                cmd.accept = in_valid;
                if (in_valid)
                begin
                    // A pop that removes a value must refetch the tops.
                    if (in_pop && stat.pop_ok)
                    begin
                        state_next = mts_pkg::S_LOAD;
                    end
                    else
                    begin
                        state_next = mts_pkg::S_FINISH;
                    end
                end
            end
            mts_pkg::S_LOAD:
            begin
                cmd.load_tops = 1'b1;
                state_next    = mts_pkg::S_FINISH;
            end
            mts_pkg::S_FINISH:
            begin
                if (stat.out_free)
                begin
                    cmd.load_out = 1'b1;
                    state_next   = mts_pkg::S_IDLE;
                end
            end
            default:
            begin
                state_next = mts_pkg::S_IDLE;
            end
        endcase
    end

endmodule

// ----- hw/rtl/mts_dp.sv -----
module mts_dp
#(
    parameter int STACK_DEPTH = mts_pkg::STACK_DEPTH_DEF
)
(
    input  logic                        clk,
    input  logic                        rst_n,
    input  mts_pkg::dp_cmd_t            cmd,
    output mts_pkg::dp_stat_t           stat,
    input  logic                        in_pop,
    input  logic [mts_pkg::DATA_W-1:0]  in_data,
    output logic                        out_valid,
    input  logic                        out_ready,
    output logic [mts_pkg::OUT_W-1:0]   out_data
);

    localparam int CW = $clog2(STACK_DEPTH + 1);
    localparam int AW = $clog2(STACK_DEPTH);
    localparam int DW = mts_pkg::DATA_W;

    logic [DW-1:0] value_mem [STACK_DEPTH];
    logic [DW-1:0] minimum_mem [STACK_DEPTH];

    logic [CW-1:0]        vcount_reg;
    logic [CW-1:0]        mcount_reg;
    logic signed [DW-1:0] vtop_reg;
    logic signed [DW-1:0] mtop_reg;
    logic [DW-1:0]        vrd_reg;
    logic [DW-1:0]        mrd_reg;
    logic                 pop_min_reg;
    mts_pkg::status_t     status_reg;
    logic                 out_valid_reg;
    logic [mts_pkg::OUT_W-1:0] out_data_reg;

    logic          push_ok;
    logic          pop_ok;
    logic          min_push;
    logic          pop_min;
    logic [CW-1:0] vrd_addr;
    logic [CW-1:0] mrd_addr;
    logic [DW-1:0] res_top;
    logic [DW-1:0] res_min;
    logic          res_empty;

    assign push_ok  = (vcount_reg != CW'(STACK_DEPTH));
    assign pop_ok   = (vcount_reg != '0);
    assign min_push = ((mcount_reg == '0) || ($signed(in_data) <= mtop_reg))
                      && (mcount_reg != CW'(STACK_DEPTH));
    assign pop_min  = (mcount_reg != '0) && (vtop_reg == mtop_reg);
    // Entry just below the top; the new minimum sits one below the old one.
    assign vrd_addr = vcount_reg - CW'(2);
    assign mrd_addr = mcount_reg - CW'(2);

    assign stat.pop_ok   = pop_ok;
    assign stat.out_free = !out_valid_reg || out_ready;

    always_ff @(posedge clk)
    begin
        if (cmd.accept && !in_pop && push_ok)
        begin
            value_mem[vcount_reg[AW-1:0]] <= in_data;
            if (min_push)
            begin
                minimum_mem[mcount_reg[AW-1:0]] <= in_data;
            end
        end
        if (cmd.accept && in_pop)
        begin
            vrd_reg <= value_mem[vrd_addr[AW-1:0]];
            mrd_reg <= minimum_mem[mrd_addr[AW-1:0]];
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            vcount_reg <= '0;
            mcount_reg <= '0;
        end
        else if (cmd.accept)
        begin
            if (!in_pop && push_ok)
            begin
                vcount_reg <= vcount_reg + CW'(1);
                if (min_push)
                begin
                    mcount_reg <= mcount_reg + CW'(1);
                end
            end
            else if (in_pop && pop_ok)
            begin
                vcount_reg <= vcount_reg - CW'(1);
                if (pop_min)
                begin
                    mcount_reg <= mcount_reg - CW'(1);
                end
            end
        end
    end

    always_ff @(posedge clk)
    begin
        if (cmd.accept)
        begin
            pop_min_reg <= pop_min;
            if (!in_pop)
            begin
                status_reg <= push_ok ? mts_pkg::ST_OK : mts_pkg::ST_OVERFLOW;
                if (push_ok)
                begin
                    vtop_reg <= $signed(in_data);
                    if (min_push)
                    begin
                        mtop_reg <= $signed(in_data);
                    end
                end
            end
            else
            begin
                status_reg <= pop_ok ? mts_pkg::ST_OK : mts_pkg::ST_UNDERFLOW;
            end
        end
        else if (cmd.load_tops)
        begin
            vtop_reg <= $signed(vrd_reg);
            if (pop_min_reg)
            begin
                mtop_reg <= $signed(mrd_reg);
            end
        end
    end

    assign res_empty = (vcount_reg == '0);
    assign res_top   = res_empty ? '0 : vtop_reg;
    assign res_min   = (res_empty || (mcount_reg == '0)) ? '0 : mtop_reg;

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            out_valid_reg <= 1'b0;
        end
        else if (cmd.load_out)
        begin
            out_valid_reg <= 1'b1;
        end
        else if (out_ready)
        begin
            out_valid_reg <= 1'b0;
        end
    end

    always_ff @(posedge clk)
    begin
        if (cmd.load_out)
        begin
            out_data_reg <= {5'b0, status_reg, res_empty, res_min, res_top};
        end
    end

    assign out_valid = out_valid_reg;
    assign out_data  = out_data_reg;

endmodule

// ----- hw/rtl/min_tracking_stack.sv -----
// Stack of signed 32-bit values that also reports the smallest value it
// holds. Each input word is a push (s_tuser 0) or a pop (s_tuser 1), and each
// one returns exactly one output word with the new top, the new minimum, an
// empty flag and a status code (ok, overflow on a push to a full stack,
// underflow on a pop from an empty stack; both error cases leave the stack
// unchanged). Top and minimum read as zero when the stack is empty. The block
// works on one word at a time: a push or a failed pop goes from the idle state
// through the finish state into the output register, and a successful pop also
// passes a load state, since the entries below the top must be fetched through
// the registered read port of the stack memories before the top registers are
// refreshed. A new word is taken as soon as the result of the previous one has
// moved into the output register. The stacks need no clearing pass after reset;
// only the fill counts are reset.
module min_tracking_stack
#(
    parameter int STACK_DEPTH = mts_pkg::STACK_DEPTH_DEF
)
(
    input  logic        clk,
    input  logic        rst_n,
    input  logic        s_tvalid,
    output logic        s_tready,
    input  logic [31:0] s_tdata,   // [31:0] data_value
    input  logic        s_tuser,   // [0] mode (0 push, 1 pop)
    output logic        m_tvalid,
    input  logic        m_tready,
    output logic [71:0] m_tdata    // [31:0] top_value, [63:32] min_value,
                                   // [64] is_empty, [66:65] status, rest zero
);

    mts_pkg::dp_cmd_t  cmd;
    mts_pkg::dp_stat_t stat;

    // The controller sequences accept, top refresh and result hand-off.
    mts_ctrl u_ctrl
    (
        .clk      (clk),
        .rst_n    (rst_n),
        .in_valid (s_tvalid),
        .in_pop   (s_tuser),
        .in_ready (s_tready),
        .stat     (stat),
        .cmd      (cmd)
    );

    // The datapath holds the two stack memories, the counts, the cached
    // tops and the output register.
    mts_dp #(.STACK_DEPTH(STACK_DEPTH)) u_dp
    (
        .clk       (clk),
        .rst_n     (rst_n),
        .cmd       (cmd),
        .stat      (stat),
        .in_pop    (s_tuser),
        .in_data   (s_tdata),
        .out_valid (m_tvalid),
        .out_ready (m_tready),
        .out_data  (m_tdata)
    );

    // After a word is accepted the block is not ready again in the next cycle.
    a_busy_after_accept: assert property (@(posedge clk) disable iff (!rst_n)
        (s_tvalid && s_tready) |=> !s_tready)
        else $error("input accepted in back-to-back cycles");

    // An underflow reports the empty stack.
    a_underflow_empty: assert property (@(posedge clk) disable iff (!rst_n)
        (m_tvalid && (m_tdata[66:65] == mts_pkg::ST_UNDERFLOW))
        |-> (m_tdata[64] && (m_tdata[31:0] == 32'd0) && (m_tdata[63:32] == 32'd0)))
        else $error("underflow result does not show an empty stack");

    // An overflow can only happen on a non-empty stack.
    a_overflow_full: assert property (@(posedge clk) disable iff (!rst_n)
        (m_tvalid && (m_tdata[66:65] == mts_pkg::ST_OVERFLOW)) |-> !m_tdata[64])
        else $error("overflow reported with an empty stack");

    // An empty stack always reads zero top and minimum.
    a_empty_zero: assert property (@(posedge clk) disable iff (!rst_n)
        (m_tvalid && m_tdata[64])
        |-> ((m_tdata[31:0] == 32'd0) && (m_tdata[63:32] == 32'd0)))
        else $error("empty stack reports a nonzero top or minimum");

endmodule
